### hw/rtl/assert_macros.svh
// Assertion macros used by the allocator sequencer, bpa_ctrl.
// Needs nothing but a clock, an active-low reset and two boolean expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/bpa_pkg.sv
// Shared types, codes and helpers for the bitmap page allocator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package bpa_pkg;

    localparam int DEF_BITMAP_WORDS   = 1024;
    localparam int DEF_RESERVED_PAGES = 512;
    localparam int WORD_BITS          = 32;
    localparam int IDX_W              = 15;
    localparam int USED_W             = 16;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic {
        STAT_OK  = 1'b0,
        STAT_OOM = 1'b1
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_TOP,
        ST_SUM,
        ST_WORD,
        ST_FREE
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [IDX_W-1:0]    page_index;
        logic [USED_W-1:0]   used_pages;
    } res_t;

    function automatic int addr_w(input int n);
        return (n <= 1) ? 1 : $clog2(n);
    endfunction

    function automatic logic [4:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [4:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                pos = 5'(i);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/bpa_ram32.sv
// Single-port 32-bit wide synchronous RAM with a registered read.
// Depends on bpa_pkg for the word width, default depth and address width helper.
`default_nettype none

module bpa_ram32
    import bpa_pkg::*;
#(
    parameter int  DEPTH = DEF_BITMAP_WORDS,
    localparam int AW    = addr_w(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic                 we,
    input  wire logic [AW-1:0]        addr,
    input  wire logic [WORD_BITS-1:0] wdata,
    output logic      [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem_reg [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en && we) begin
            mem_reg[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && !we) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/bpa_ctrl.sv
// Allocator sequencer: clearing pass, summary-guided first-fit search, free,
// and the used-page count. Depends on bpa_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module bpa_ctrl
    import bpa_pkg::*;
#(
    parameter int  BITMAP_WORDS   = DEF_BITMAP_WORDS,
    parameter int  RESERVED_PAGES = DEF_RESERVED_PAGES,
    localparam int WORD_AW        = addr_w(BITMAP_WORDS),
    localparam int SUM_WORDS      = (BITMAP_WORDS + WORD_BITS - 1) / WORD_BITS,
    localparam int SUM_AW         = addr_w(SUM_WORDS)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_op,
    input  wire logic [IDX_W-1:0]     s_page_index,
    output logic                      s_ready,
    input  wire logic                 buf_free,
    output logic                      res_valid,
    output res_t                      res,
    output logic                      bm_en,
    output logic                      bm_we,
    output logic      [WORD_AW-1:0]   bm_addr,
    output logic      [WORD_BITS-1:0] bm_wdata,
    input  wire logic [WORD_BITS-1:0] bm_rdata,
    output logic                      sm_en,
    output logic                      sm_we,
    output logic      [SUM_AW-1:0]    sm_addr,
    output logic      [WORD_BITS-1:0] sm_wdata,
    input  wire logic [WORD_BITS-1:0] sm_rdata
);

    localparam int TOP_CHUNKS  = (SUM_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int CH_AW       = addr_w(TOP_CHUNKS);
    localparam int TOTAL_PAGES = BITMAP_WORDS * WORD_BITS;
    localparam int RC          = (RESERVED_PAGES > TOTAL_PAGES) ? TOTAL_PAGES : RESERVED_PAGES;
    localparam int R_WORD      = RC / WORD_BITS;
    localparam int R_LOW       = RC % WORD_BITS;
    localparam logic [WORD_BITS-1:0] LOW_MASK = WORD_BITS'((64'd1 << R_LOW) - 64'd1);
    localparam int CNT_W       = $clog2(TOTAL_PAGES + 1);

    function automatic logic [WORD_BITS-1:0] init_word(input logic [WORD_AW-1:0] i);
        logic [WORD_BITS-1:0] v;
        if (32'(i) < 32'(R_WORD)) begin
            v = '1;
        end else if (32'(i) == 32'(R_WORD)) begin
            v = LOW_MASK;
        end else begin
            v = '0;
        end
        return v;
    endfunction

    function automatic logic [WORD_BITS-1:0] init_sum(input logic [SUM_AW-1:0] s);
        logic [WORD_BITS-1:0] v;
        logic [31:0]          j;
        v = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            j    = (32'(s) << 5) | 32'(b);
            v[b] = (j < 32'(R_WORD)) || (j >= 32'(BITMAP_WORDS));
        end
        return v;
    endfunction

    function automatic logic [TOP_CHUNKS-1:0][WORD_BITS-1:0] init_top();
        logic [TOP_CHUNKS-1:0][WORD_BITS-1:0] v;
        int t;
        int hi;
        v = '0;
        for (int c = 0; c < TOP_CHUNKS; c++) begin
            for (int b = 0; b < WORD_BITS; b++) begin
                t  = c * WORD_BITS + b;
                hi = (t * WORD_BITS + WORD_BITS < BITMAP_WORDS) ?
                     t * WORD_BITS + WORD_BITS : BITMAP_WORDS;
                v[c][b] = (t >= SUM_WORDS) || (hi <= R_WORD);
            end
        end
        return v;
    endfunction

    state_t                               state_reg, state_next;
    logic [WORD_AW-1:0]                   init_idx_reg;
    logic [CH_AW-1:0]                     chunk_reg;
    logic [CNT_W-1:0]                     count_reg, count_next;
    logic [TOP_CHUNKS-1:0][WORD_BITS-1:0] top_vec_reg;
    logic [SUM_AW-1:0]                    sum_addr_reg;
    logic [WORD_AW-1:0]                   word_addr_reg;
    logic [4:0]                           sum_pos_reg;
    logic [4:0]                           fr_bit_reg;
    logic                                 fr_in_range_reg;

    logic                 accept;
    logic [31:0]          p32;
    logic [31:0]          top_s32;
    logic [31:0]          sum_w32;
    logic [31:0]          res_i32;
    logic [31:0]          sa32;
    logic [31:0]          init32;
    logic [31:0]          cnt32;
    logic [WORD_BITS-1:0] chunk_word;
    logic                 chunk_has_zero;
    logic                 chunk_last;
    logic [4:0]           top_pos;
    logic [4:0]           sum_pos;
    logic [4:0]           bm_pos;
    logic [WORD_BITS-1:0] alloc_word;
    logic [WORD_BITS-1:0] alloc_sum;
    logic [WORD_BITS-1:0] fr_mask;
    logic                 fr_hit;
    logic [CH_AW-1:0]     sa_chunk;
    logic [4:0]           sa_bit;
    logic                 top_set;
    logic                 top_clr;
    logic                 init_last;
    logic                 init_sum_ok;
    logic [SUM_AW-1:0]    init_saddr;

    assign accept         = (state_reg == ST_IDLE) && s_valid && buf_free;
    assign p32            = 32'(s_page_index);
    assign chunk_word     = top_vec_reg[chunk_reg];
    assign chunk_has_zero = (chunk_word != '1);
    assign chunk_last     = (chunk_reg == CH_AW'(TOP_CHUNKS - 1));
    assign top_pos        = lowest_zero(chunk_word);
    assign sum_pos        = lowest_zero(sm_rdata);
    assign bm_pos         = lowest_zero(bm_rdata);
    assign top_s32        = (32'(chunk_reg) << 5) | 32'(top_pos);
    assign sum_w32        = (32'(sum_addr_reg) << 5) | 32'(sum_pos);
    assign res_i32        = (32'(word_addr_reg) << 5) | 32'(bm_pos);
    assign sa32           = 32'(sum_addr_reg);
    assign sa_chunk       = sa32[5 +: CH_AW];
    assign sa_bit         = sa32[4:0];
    assign alloc_word     = bm_rdata | (WORD_BITS'(1) << bm_pos);
    assign alloc_sum      = sm_rdata | (WORD_BITS'(&alloc_word) << sum_pos_reg);
    assign fr_mask        = WORD_BITS'(1) << fr_bit_reg;
    assign fr_hit         = |(bm_rdata & fr_mask);
    assign init32         = 32'(init_idx_reg);
    assign init_last      = (init_idx_reg == WORD_AW'(BITMAP_WORDS - 1));
    assign init_sum_ok    = (init32 < 32'(SUM_WORDS));
    assign init_saddr     = init32[SUM_AW-1:0];
    assign cnt32          = 32'(count_next);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (init_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = (op_t'(s_op) == OP_FREE) ? ST_FREE : ST_TOP;
                end
            end
            ST_TOP: begin
                if (chunk_has_zero) begin
                    state_next = ST_SUM;
                end else if (chunk_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SUM:  state_next = ST_WORD;
            ST_WORD: state_next = ST_IDLE;
            ST_FREE: state_next = ST_IDLE;
            default: state_next = ST_INIT;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        bm_en          = 1'b0;
        bm_we          = 1'b0;
        bm_addr        = word_addr_reg;
        bm_wdata       = '0;
        sm_en          = 1'b0;
        sm_we          = 1'b0;
        sm_addr        = sum_addr_reg;
        sm_wdata       = '0;
        res_valid      = 1'b0;
        res.status     = STAT_OK;
        res.page_index = '0;
        count_next     = count_reg;
        top_set        = 1'b0;
        top_clr        = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                bm_en    = 1'b1;
                bm_we    = 1'b1;
                bm_addr  = init_idx_reg;
                bm_wdata = init_word(init_idx_reg);
                sm_en    = init_sum_ok;
                sm_we    = init_sum_ok;
                sm_addr  = init_saddr;
                sm_wdata = init_sum(init_saddr);
            end
            ST_IDLE: begin
                s_ready = buf_free;
                if (accept && (op_t'(s_op) == OP_FREE)) begin
                    bm_en   = 1'b1;
                    bm_addr = p32[5 +: WORD_AW];
                    sm_en   = 1'b1;
                    sm_addr = p32[10 +: SUM_AW];
                end
            end
            ST_TOP: begin
                if (chunk_has_zero) begin
                    sm_en   = 1'b1;
                    sm_addr = top_s32[SUM_AW-1:0];
                end else if (chunk_last) begin
                    res_valid  = 1'b1;
                    res.status = STAT_OOM;
                end
            end
            ST_SUM: begin
                bm_en   = 1'b1;
                bm_addr = sum_w32[WORD_AW-1:0];
            end
            ST_WORD: begin
                bm_en          = 1'b1;
                bm_we          = 1'b1;
                bm_wdata       = alloc_word;
                sm_en          = 1'b1;
                sm_we          = 1'b1;
                sm_wdata       = alloc_sum;
                top_set        = &alloc_sum;
                count_next     = count_reg + CNT_W'(1);
                res_valid      = 1'b1;
                res.page_index = res_i32[IDX_W-1:0];
            end
            ST_FREE: begin
                res_valid = 1'b1;
                if (fr_in_range_reg) begin
                    bm_en    = 1'b1;
                    bm_we    = 1'b1;
                    bm_wdata = bm_rdata & ~fr_mask;
                    sm_en    = 1'b1;
                    sm_we    = 1'b1;
                    sm_wdata = sm_rdata & ~(WORD_BITS'(1) << sum_pos_reg);
                    top_clr  = 1'b1;
                    if (fr_hit) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: ;
        endcase
        res.used_pages = (cnt32 > 32'hFFFF) ? USED_W'(16'hFFFF) : cnt32[USED_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            init_idx_reg <= '0;
            chunk_reg    <= '0;
            count_reg    <= CNT_W'(RC);
            top_vec_reg  <= init_top();
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == ST_INIT) begin
                init_idx_reg <= init_idx_reg + WORD_AW'(1);
            end
            if (accept) begin
                chunk_reg <= '0;
            end else if ((state_reg == ST_TOP) && !chunk_has_zero && !chunk_last) begin
                chunk_reg <= chunk_reg + CH_AW'(1);
            end
            if (top_set) begin
                top_vec_reg[sa_chunk][sa_bit] <= 1'b1;
            end else if (top_clr) begin
                top_vec_reg[sa_chunk][sa_bit] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_addr_reg   <= p32[5 +: WORD_AW];
            sum_addr_reg    <= p32[10 +: SUM_AW];
            sum_pos_reg     <= p32[9:5];
            fr_bit_reg      <= p32[4:0];
            fr_in_range_reg <= (p32 < 32'(TOTAL_PAGES));
        end else if ((state_reg == ST_TOP) && chunk_has_zero) begin
            sum_addr_reg <= top_s32[SUM_AW-1:0];
        end else if (state_reg == ST_SUM) begin
            word_addr_reg <= sum_w32[WORD_AW-1:0];
            sum_pos_reg   <= sum_pos;
        end
    end

    `BPA_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, 32'(count_reg) <= 32'(TOTAL_PAGES))
    `BPA_ASSERT_IMP(a_sum_has_free, aclk, aresetn, state_reg == ST_SUM, sm_rdata != '1)
    `BPA_ASSERT_IMP(a_word_has_free, aclk, aresetn, state_reg == ST_WORD, bm_rdata != '1)
    `BPA_ASSERT_NXT(a_alloc_count, aclk, aresetn, state_reg == ST_WORD, 32'(count_reg) == 32'($past(count_reg)) + 32'd1)
    `BPA_ASSERT_IMP(a_init_quiet, aclk, aresetn, state_reg == ST_INIT, !res_valid && !s_ready)

endmodule

`default_nettype wire

### hw/rtl/bitmap_page_allocator_top.sv
// Top level of the bitmap page allocator: bitmap and summary RAMs, the
// sequencer and a two-entry result buffer. Depends on bpa_pkg and all bpa_ modules.
`default_nettype none

// First-fit physical page allocator with one bitmap bit per page and a
// one-bit-per-word "full" summary kept in a second RAM, plus a small flop
// vector with one bit per summary word. After reset a clearing pass writes
// the reserved pattern, one bitmap word per cycle, over all BITMAP_WORDS
// words, and s_ready stays low until it ends. An allocate scans the summary
// flops in 32-bit slices up to the first slice with a free word, then reads
// the summary word and then the bitmap word from RAM, and writes both back
// at the end. An out-of-memory allocate scans every slice and then reports
// STAT_OOM; a free reads both words and, for a page in range, writes them
// back. Results are buffered, so a new request is taken while an earlier
// result waits on m_ready, as long as the second buffer entry is free.
module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int BITMAP_WORDS   = DEF_BITMAP_WORDS,
    parameter int RESERVED_PAGES = DEF_RESERVED_PAGES
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_op,
    input  wire logic [IDX_W-1:0]  s_page_index,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_status,
    output logic      [IDX_W-1:0]  m_page_index_res,
    output logic      [USED_W-1:0] m_used_pages
);

    localparam int WORD_AW   = addr_w(BITMAP_WORDS);
    localparam int SUM_WORDS = (BITMAP_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int SUM_AW    = addr_w(SUM_WORDS);

    logic                 buf_free;
    logic                 res_valid;
    res_t                 res;
    logic                 bm_en, bm_we, sm_en, sm_we;
    logic [WORD_AW-1:0]   bm_addr;
    logic [SUM_AW-1:0]    sm_addr;
    logic [WORD_BITS-1:0] bm_wdata, bm_rdata, sm_wdata, sm_rdata;

    logic out_valid_reg, pend_valid_reg;
    res_t out_reg, pend_reg;
    logic out_space;

    bpa_ctrl #(
        .BITMAP_WORDS   (BITMAP_WORDS),
        .RESERVED_PAGES (RESERVED_PAGES)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_op         (s_op),
        .s_page_index (s_page_index),
        .s_ready      (s_ready),
        .buf_free     (buf_free),
        .res_valid    (res_valid),
        .res          (res),
        .bm_en        (bm_en),
        .bm_we        (bm_we),
        .bm_addr      (bm_addr),
        .bm_wdata     (bm_wdata),
        .bm_rdata     (bm_rdata),
        .sm_en        (sm_en),
        .sm_we        (sm_we),
        .sm_addr      (sm_addr),
        .sm_wdata     (sm_wdata),
        .sm_rdata     (sm_rdata)
    );

    bpa_ram32 #(.DEPTH(BITMAP_WORDS)) u_bitmap (
        .aclk  (aclk),
        .en    (bm_en),
        .we    (bm_we),
        .addr  (bm_addr),
        .wdata (bm_wdata),
        .rdata (bm_rdata)
    );

    bpa_ram32 #(.DEPTH(SUM_WORDS)) u_summary (
        .aclk  (aclk),
        .en    (sm_en),
        .we    (sm_we),
        .addr  (sm_addr),
        .wdata (sm_wdata),
        .rdata (sm_rdata)
    );

    assign buf_free  = !pend_valid_reg;
    assign out_space = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (out_space) begin
            out_valid_reg  <= pend_valid_reg || res_valid;
            pend_valid_reg <= pend_valid_reg && res_valid;
        end else if (res_valid) begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_space) begin
            if (pend_valid_reg) begin
                out_reg <= pend_reg;
                if (res_valid) begin
                    pend_reg <= res;
                end
            end else if (res_valid) begin
                out_reg <= res;
            end
        end else if (res_valid) begin
            pend_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_reg.status;
    assign m_page_index_res = out_reg.page_index;
    assign m_used_pages     = out_reg.used_pages;

endmodule

`default_nettype wire
